// File: src/sasm_pkg.sv
// shared constants, codes and control structs of the slot allocator
package sasm_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int ID_WIDTH  = 16;
   localparam int SLOT_W    = 6;
   localparam int POS_W     = 6;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_LOOKUP  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_FREE     = 2'd1,
      STAT_NOT_FOUND   = 2'd2,
      STAT_BAD_RELEASE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // table cell: load a new entry, or take the upper neighbor's entry
   typedef struct packed {
      logic load;
      logic shift;
   } table_ctl_type;

   // free stack cell: push moves entries away from the top, pop toward it
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

// File: src/sasm_if.sv
// valid/ready channel interfaces for request, response and csr write

interface sasm_req_if import sasm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ID_WIDTH-1:0] team_id;
   logic [SLOT_W-1:0]   slot_in;
   logic [POS_W-1:0]    position_in;

   modport source (output valid, mode, team_id, slot_in, position_in, input ready);
   modport sink   (input valid, mode, team_id, slot_in, position_in, output ready);
endinterface

interface sasm_rsp_if import sasm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_out;
   logic [POS_W-1:0]    position_out;

   modport source (output valid, status, slot_out, position_out, input ready);
   modport sink   (input valid, status, slot_out, position_out, output ready);
endinterface

interface sasm_csr_if import sasm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: src/slot_allocator_sorted_map_top.sv
// top level of the slot allocator: free slot stack plus ordered id table
// usage:
//   req_chan carries one operation per item: allocate, release or lookup.
//   rsp_chan returns exactly one result item per request item, in order.
//   csr_chan writes the all-team id; it is always ready and takes effect
//   on the next item. write it only while the block is idle.
// throughput and search:
//   allocate, release, the unused mode, and a lookup that hits the
//   all-team id or sees an empty table: result valid in the cycle after the
//   request is taken; a new request can be taken every cycle while each result is taken.
//   other lookups run a lower-bound binary search, one step per cycle over
//   the table cells, with k steps (k up to log2 of the slot count, 6 here);
//   no request is taken until its result is valid. the search step is the
//   one-bit select of a cell's compare flag, so the search loop sets the
//   lookup time.
// reset:
//   synchronous; the stack holds every slot with slot 0 on top, the table
//   is empty and the all-team id is 0. no clearing pass is needed.
// stalls:
//   the result sits in an output register; while it is not taken, no new
//   request is taken, and a pending result is never lost.
module slot_allocator_sorted_map_top import sasm_pkg::*; (
   input  logic clock,
   input  logic reset,
   sasm_req_if.sink   req_chan,
   sasm_rsp_if.source rsp_chan,
   sasm_csr_if.sink   csr_chan
);

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    free_count_ff, free_count_in;
   logic [CNT_W-1:0]    table_count_ff, table_count_in;
   logic [ID_WIDTH-1:0] all_team_id_ff, all_team_id_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ID_WIDTH-1:0] key_ff, key_in;
   logic [POS_W-1:0]    lo_ff, lo_in;
   logic [POS_W-1:0]    hi_ff, hi_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   // cell row views
   logic [ID_WIDTH-1:0] cell_id   [MAX_SLOTS];
   logic [SLOT_W-1:0]   cell_slot [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] cell_lt;
   logic [MAX_SLOTS-1:0] cell_eq;
   table_ctl_type       tctl      [MAX_SLOTS];
   logic [SLOT_W-1:0]   stack_val [MAX_SLOTS];
   stack_ctl_type       sctl;

   logic              req_fire;
   logic              alloc_ok;
   logic              release_ok;
   logic              lookup_quick;
   logic              search_done;
   logic [POS_W:0]    mid_sum;
   logic [POS_W-1:0]  mid;

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign alloc_ok     = (free_count_ff != '0) &&
                         (table_count_ff < CNT_W'(MAX_SLOTS));
   assign release_ok   = (free_count_ff < CNT_W'(MAX_SLOTS)) &&
                         ({1'b0, req_chan.position_in} < table_count_ff);
   assign lookup_quick = (req_chan.team_id == all_team_id_ff) ||
                         (table_count_ff == '0);
   assign search_done  = (lo_ff == hi_ff);
   assign mid_sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid          = mid_sum[POS_W:1];

   // config port never stalls
   assign csr_chan.ready = 1'b1;
   assign all_team_id_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data
                                                              : all_team_id_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.mode == MODE_LOOKUP) && !lookup_quick) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and results
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
      sctl           = '0;
      free_count_in  = free_count_ff;
      table_count_in = table_count_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_pos_in     = rsp_pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_slot_in   = '0;
               rsp_pos_in    = '0;
               case (req_chan.mode)
                  MODE_ALLOC: begin
                     if (alloc_ok) begin
                        sctl.pop       = 1'b1;
                        free_count_in  = free_count_ff - 1'b1;
                        table_count_in = table_count_ff + 1'b1;
                        rsp_slot_in    = stack_val[0];
                        rsp_pos_in     = table_count_ff[POS_W-1:0];
                     end else begin
                        rsp_status_in = STAT_NO_FREE;
                     end
                  end
                  MODE_RELEASE: begin
                     if (release_ok) begin
                        sctl.push      = 1'b1;
                        free_count_in  = free_count_ff + 1'b1;
                        table_count_in = table_count_ff - 1'b1;
                     end else begin
                        rsp_status_in = STAT_BAD_RELEASE;
                     end
                  end
                  MODE_LOOKUP: begin
                     key_in = req_chan.team_id;
                     lo_in  = '0;
                     hi_in  = POS_W'(table_count_ff - 1'b1);
                     if (req_chan.team_id == all_team_id_ff) begin
                        rsp_status_in = STAT_OK;
                     end else if (table_count_ff == '0) begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        // result comes from the search
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (search_done) begin
               rsp_valid_in = 1'b1;
               if (cell_eq[lo_ff]) begin
                  rsp_status_in = STAT_OK;
                  rsp_slot_in   = cell_slot[lo_ff];
                  rsp_pos_in    = lo_ff;
               end else begin
                  rsp_status_in = STAT_NOT_FOUND;
                  rsp_slot_in   = '0;
                  rsp_pos_in    = '0;
               end
            end else if (cell_lt[mid]) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // table cells: entry i loads on allocate at i, shifts down on release at or below i
   genvar gi;
   generate
      for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_table
         logic [ID_WIDTH-1:0] nxt_id;
         logic [SLOT_W-1:0]   nxt_slot;

         if (gi == MAX_SLOTS - 1) begin : g_last
            assign nxt_id   = cell_id[gi];
            assign nxt_slot = cell_slot[gi];
         end else begin : g_mid
            assign nxt_id   = cell_id[gi+1];
            assign nxt_slot = cell_slot[gi+1];
         end

         assign tctl[gi].load  = req_fire && (req_chan.mode == MODE_ALLOC) && alloc_ok &&
                                 (table_count_ff[POS_W-1:0] == POS_W'(gi));
         assign tctl[gi].shift = req_fire && (req_chan.mode == MODE_RELEASE) && release_ok &&
                                 (req_chan.position_in <= POS_W'(gi));

         sasm_table_cell u_cell (
            .clock     (clock),
            .ctl       (tctl[gi]),
            .load_id   (req_chan.team_id),
            .load_slot (stack_val[0]),
            .next_id   (nxt_id),
            .next_slot (nxt_slot),
            .key       (key_ff),
            .id_out    (cell_id[gi]),
            .slot_out  (cell_slot[gi]),
            .lt        (cell_lt[gi]),
            .eq        (cell_eq[gi])
         );
      end
   endgenerate

   // free stack cells: cell j holds slot j after reset, slot 0 on top
   generate
      for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_stack
         logic [SLOT_W-1:0] prv;
         logic [SLOT_W-1:0] nxt;

         if (gi == 0) begin : g_top
            assign prv = req_chan.slot_in;
         end else begin : g_below
            assign prv = stack_val[gi-1];
         end
         if (gi == MAX_SLOTS - 1) begin : g_bottom
            assign nxt = stack_val[gi];
         end else begin : g_above
            assign nxt = stack_val[gi+1];
         end

         sasm_stack_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .init_value (SLOT_W'(gi)),
            .ctl        (sctl),
            .prev_value (prv),
            .next_value (nxt),
            .value      (stack_val[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_count_ff  <= CNT_W'(MAX_SLOTS);
         table_count_ff <= '0;
         all_team_id_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_count_ff  <= free_count_in;
         table_count_ff <= table_count_in;
         all_team_id_ff <= all_team_id_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot_out     = rsp_slot_ff;
   assign rsp_chan.position_out = rsp_pos_ff;

`ifndef ASSERT_OFF
   // every slot is either free or owned by a table entry
   a_slot_conservation: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff + table_count_ff) == CNT_W'(MAX_SLOTS))
      else $error("free and table counts do not add up to the slot count");

   // search window stays ordered
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff <= hi_ff))
      else $error("search window inverted");

   // search never looks past the filled part of the table
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ({1'b0, hi_ff} < table_count_ff))
      else $error("search window beyond table count");

   // output register is empty while a search runs
   a_search_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> !rsp_valid_ff)
      else $error("result pending during search");

   // a table change follows only from an accepted item
   a_table_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> (table_count_ff == $past(table_count_ff)))
      else $error("table count changed without an accepted item");
`endif

endmodule

// File: src/sasm_table_cell.sv
// one entry of the ordered id table, with its own key compare
module sasm_table_cell import sasm_pkg::*; (
   input  logic                clock,
   input  table_ctl_type       ctl,
   input  logic [ID_WIDTH-1:0] load_id,
   input  logic [SLOT_W-1:0]   load_slot,
   input  logic [ID_WIDTH-1:0] next_id,
   input  logic [SLOT_W-1:0]   next_slot,
   input  logic [ID_WIDTH-1:0] key,
   output logic [ID_WIDTH-1:0] id_out,
   output logic [SLOT_W-1:0]   slot_out,
   output logic                lt,
   output logic                eq
);

   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   always_comb begin
      id_in   = id_ff;
      slot_in = slot_ff;
      if (ctl.load) begin
         id_in   = load_id;
         slot_in = load_slot;
      end else if (ctl.shift) begin
         id_in   = next_id;
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      slot_ff <= slot_in;
   end

   assign id_out   = id_ff;
   assign slot_out = slot_ff;
   assign lt       = (id_ff < key);
   assign eq       = (id_ff == key);

endmodule

// File: src/sasm_stack_cell.sv
// one entry of the free slot stack, top of stack is cell zero
module sasm_stack_cell import sasm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] init_value,
   input  stack_ctl_type     ctl,
   input  logic [SLOT_W-1:0] prev_value,
   input  logic [SLOT_W-1:0] next_value,
   output logic [SLOT_W-1:0] value
);

   logic [SLOT_W-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         value_in = prev_value;
      end else if (ctl.pop) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= init_value;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: sim/tb.sv
// self-checking testbench for the slot allocator with its own model of stack, table and all-team id
`timescale 1ns / 100ps

module tb;
   import sasm_pkg::*;

   // mode 3 is not decoded by the block, it must answer ok with zeros
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int WATCHDOG_LIMIT  = 500;   // cycles with no handshake at all
   localparam int END_SETTLE      = 12;    // margin past the longest lookup
   localparam int MAX_REPORTS     = 10;

   typedef enum int {
      TREND_FILL,
      TREND_DRAIN,
      TREND_MIX
   } trend_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ID_WIDTH-1:0] team_id;
      logic [SLOT_W-1:0]   slot_in;
      logic [POS_W-1:0]    position_in;
   } op_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  pos;
   } outcome_type;

   // one line of the directed table; typed rows carry a hand-written answer
   typedef struct packed {
      op_type      op;
      logic        typed;
      outcome_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   sasm_req_if req_bus ();
   sasm_rsp_if rsp_bus ();
   sasm_csr_if csr_bus ();

   slot_allocator_sorted_map_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // ---------------------------------------------------------------
   // model of the allocator state
   // ---------------------------------------------------------------
   logic [SLOT_W-1:0]   free_stack [MAX_SLOTS];
   int                  free_cnt;
   logic [ID_WIDTH-1:0] tbl_id   [MAX_SLOTS];
   logic [SLOT_W-1:0]   tbl_slot [MAX_SLOTS];
   int                  tbl_cnt;
   logic [ID_WIDTH-1:0] all_team;

   // results owed by the block, oldest first
   outcome_type awaited_rsp [$];

   // bookkeeping for the checker and the summary
   int  fail_count = 0;
   int  mode_seen [4];
   int  status_seen [4];
   int  csr_writes;
   int  rsp_seen = 0;

   // idling knobs, changed per phase
   int  src_idle_pct;
   int  snk_idle_pct;
   bit  no_idle;
   int  sink_hold = 0;
   int  idle_cycles = 0;

   // next id handed out by well-formed allocates, kept increasing
   int  next_id;

   stim_row_type stim_rows [$];

   // after reset: every slot free with slot 0 on top, empty table
   task automatic reset_model();
      for (int k = 0; k < MAX_SLOTS; k++) begin
         free_stack[k] = SLOT_W'(MAX_SLOTS - 1 - k);
         tbl_id[k]     = '0;
         tbl_slot[k]   = '0;
      end
      free_cnt = MAX_SLOTS;
      tbl_cnt  = 0;
      all_team = '0;
   endtask

   // apply one request to the model and return the result it owes
   function automatic outcome_type alloc_model_step(op_type op);
      outcome_type r;
      int lo;
      int hi;
      int mid;
      r.status = STAT_OK;
      r.slot   = '0;
      r.pos    = '0;
      case (op.mode)
         MODE_ALLOC: begin
            if (free_cnt == 0 || tbl_cnt >= MAX_SLOTS) begin
               r.status = STAT_NO_FREE;
            end else begin
               free_cnt--;
               tbl_id[tbl_cnt]   = op.team_id;
               tbl_slot[tbl_cnt] = free_stack[free_cnt];
               r.slot = free_stack[free_cnt];
               r.pos  = POS_W'(tbl_cnt);
               tbl_cnt++;
            end
         end
         MODE_RELEASE: begin
            if (free_cnt >= MAX_SLOTS || int'(op.position_in) >= tbl_cnt) begin
               r.status = STAT_BAD_RELEASE;
            end else begin
               free_stack[free_cnt] = op.slot_in;
               free_cnt++;
               // close the gap left by the removed entry
               for (int i = int'(op.position_in); i + 1 < tbl_cnt; i++) begin
                  tbl_id[i]   = tbl_id[i + 1];
                  tbl_slot[i] = tbl_slot[i + 1];
               end
               tbl_cnt--;
            end
         end
         MODE_LOOKUP: begin
            if (op.team_id == all_team) begin
               r.status = STAT_OK;
            end else if (tbl_cnt == 0) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               // lower-bound search, defines the answer for unsorted tables too
               lo = 0;
               hi = tbl_cnt - 1;
               while (lo < hi) begin
                  mid = (lo + hi) >> 1;
                  if (tbl_id[mid] < op.team_id) lo = mid + 1;
                  else hi = mid;
               end
               if (tbl_id[lo] == op.team_id) begin
                  r.slot = tbl_slot[lo];
                  r.pos  = POS_W'(lo);
               end else begin
                  r.status = STAT_NOT_FOUND;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic stim_row_type dir_row(logic [MODE_W-1:0] mode, logic [ID_WIDTH-1:0] id,
                                            logic [SLOT_W-1:0] slot, logic [POS_W-1:0] pos,
                                            logic typed, status_type st,
                                            logic [SLOT_W-1:0] s, logic [POS_W-1:0] p);
      stim_row_type row;
      row.op.mode        = mode;
      row.op.team_id     = id;
      row.op.slot_in     = slot;
      row.op.position_in = pos;
      row.typed          = typed;
      row.want.status    = st;
      row.want.slot      = s;
      row.want.pos       = p;
      return row;
   endfunction

   // random request; most are well formed so the table fills, drains and stays sorted
   function automatic op_type make_random_op(trend_type trend);
      op_type op;
      int  pick;
      int  alloc_pct;
      int  release_pct;
      int  k;
      op.mode        = MODE_LOOKUP;
      op.team_id     = 16'($urandom);
      op.slot_in     = SLOT_W'($urandom);
      op.position_in = POS_W'($urandom);
      case (trend)
         TREND_FILL:  begin alloc_pct = 55; release_pct = 15; end
         TREND_DRAIN: begin alloc_pct = 15; release_pct = 55; end
         default:     begin alloc_pct = 35; release_pct = 30; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise: any mode, any field values
         op.mode = MODE_W'($urandom_range(0, 3));
      end else if (pick < 8 + alloc_pct) begin
         op.mode = MODE_ALLOC;
         // new base once the table is empty, so high id bits get exercised
         if (tbl_cnt == 0) next_id = $urandom_range(0, 32767);
         if (next_id > 65535) begin
            op.team_id = 16'($urandom);   // out of order, unsorted table
         end else begin
            op.team_id = 16'(next_id);
            if (tbl_cnt < MAX_SLOTS) next_id += $urandom_range(1, 512);
         end
      end else if (pick < 8 + alloc_pct + release_pct) begin
         op.mode = MODE_RELEASE;
         if (tbl_cnt > 0) begin
            k = $urandom_range(0, tbl_cnt - 1);
            op.position_in = POS_W'(k);
            if ($urandom_range(0, 9) != 0) op.slot_in = tbl_slot[k];
         end
      end else begin
         op.mode = MODE_LOOKUP;
         pick = $urandom_range(0, 99);
         if (tbl_cnt > 0 && pick < 55) begin
            op.team_id = tbl_id[$urandom_range(0, tbl_cnt - 1)];
         end else if (tbl_cnt > 0 && pick < 70) begin
            // neighbor of a stored id, usually a miss
            op.team_id = tbl_id[$urandom_range(0, tbl_cnt - 1)] + 16'($urandom_range(0, 1) * 2 - 1);
         end else if (pick < 85) begin
            op.team_id = all_team;
         end
      end
      return op;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // present one item, wait for the handshake, then log what it owes
   task automatic send_req(op_type op, logic typed, outcome_type typed_want);
      outcome_type r;
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= op.mode;
      req_bus.team_id     <= op.team_id;
      req_bus.slot_in     <= op.slot_in;
      req_bus.position_in <= op.position_in;
      do @(posedge clock); while (!req_bus.ready);
      r = alloc_model_step(op);
      if (typed) r = typed_want;
      awaited_rsp.push_back(r);
      mode_seen[op.mode]++;
      status_seen[r.status]++;
      // random gap before the next item; otherwise valid just stays high
      if (!no_idle && $urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every owed result is back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // all-team id write; only called with the block idle
   task automatic write_all_team(logic [ID_WIDTH-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      all_team = value;
      csr_writes++;
   endtask

   // ---------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------

   // ready drops in bursts of random length
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_bus.ready <= 1'b1;
         sink_hold     <= 0;
      end else if (sink_hold != 0) begin
         sink_hold     <= sink_hold - 1;
         rsp_bus.ready <= (sink_hold == 1);
      end else if ($urandom_range(0, 99) < snk_idle_pct) begin
         sink_hold     <= $urandom_range(1, 13);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // every accepted result against the oldest one owed
   always @(posedge clock) begin : rsp_check
      outcome_type oldest;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (awaited_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("[%0t] result with none owed: status %0d slot %0d pos %0d",
                        $realtime, rsp_bus.status, rsp_bus.slot_out, rsp_bus.position_out);
         end else begin
            oldest = awaited_rsp.pop_front();
            if (rsp_bus.status !== oldest.status || rsp_bus.slot_out !== oldest.slot ||
                rsp_bus.position_out !== oldest.pos) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("[%0t] mismatch: want status %0d slot %0d pos %0d, got %0d %0d %0d",
                           $realtime, oldest.status, oldest.slot, oldest.pos,
                           rsp_bus.status, rsp_bus.slot_out, rsp_bus.position_out);
            end
         end
      end
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results owed", awaited_rsp.size());
            $display("slot_allocator_sorted_map_top verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // clock, reset and the stimulus sequence
   // ---------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin : main
      trend_type   trend;
      int          p;
      int          n;
      op_type      op;
      outcome_type none;

      // known values on every request and csr input from time zero
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_ALLOC;
      req_bus.team_id     = '0;
      req_bus.slot_in     = '0;
      req_bus.position_in = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      csr_writes   = 0;
      src_idle_pct = 20;
      snk_idle_pct = 20;
      no_idle      = 1'b0;
      next_id      = 0;
      none         = '0;
      for (int k = 0; k < 4; k++) begin
         mode_seen[k]   = 0;
         status_seen[k] = 0;
      end
      reset_model();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, all-team id still at its reset value 0
      // full stack: release refused
      stim_rows.push_back(dir_row(MODE_RELEASE, 16'h0000,  0,  0, 1, STAT_BAD_RELEASE, 0, 0));
      // all-team id maps to slot 0 without a search
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h0000,  0,  0, 1, STAT_OK,          0, 0));
      // empty table: miss
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'hFFFF,  0,  0, 1, STAT_NOT_FOUND,   0, 0));
      // unused mode answers zeros
      stim_rows.push_back(dir_row(MODE_SPARE,   16'hFFFF, 63, 63, 1, STAT_OK,          0, 0));
      // first allocates take slots 0 and 1
      stim_rows.push_back(dir_row(MODE_ALLOC,   16'h0001,  0,  0, 1, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_ALLOC,   16'h0100, 63, 63, 1, STAT_OK,          1, 1));
      stim_rows.push_back(dir_row(MODE_ALLOC,   16'h8000,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_ALLOC,   16'hFFFF,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h0100,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'hFFFF,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h0001,  0,  0, 0, STAT_OK,          0, 0));
      // id between two entries: miss
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h00FF,  0,  0, 1, STAT_NOT_FOUND,   0, 0));
      // position past the table end: release refused
      stim_rows.push_back(dir_row(MODE_RELEASE, 16'h0000, 63, 63, 1, STAT_BAD_RELEASE, 0, 0));
      stim_rows.push_back(dir_row(MODE_RELEASE, 16'h0000,  3,  4, 1, STAT_BAD_RELEASE, 0, 0));
      // release from the middle, later entries move down
      stim_rows.push_back(dir_row(MODE_RELEASE, 16'hFFFF,  1,  1, 1, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h8000,  0,  0, 0, STAT_OK,          0, 0));
      // out-of-order id leaves the table unsorted
      stim_rows.push_back(dir_row(MODE_ALLOC,   16'hFFFE,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'hFFFE,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h0100,  0,  0, 0, STAT_OK,          0, 0));
      // release a slot that was never handed out, it goes back as given
      stim_rows.push_back(dir_row(MODE_RELEASE, 16'h0000, 63,  0, 1, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_ALLOC,   16'h0002,  0,  0, 0, STAT_OK,          0, 0));
      stim_rows.push_back(dir_row(MODE_LOOKUP,  16'h0000,  0,  0, 1, STAT_OK,          0, 0));
      foreach (stim_rows[i]) send_req(stim_rows[i].op, stim_rows[i].typed, stim_rows[i].want);

      // random phases, each under its own all-team id and idling mix
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         if (p == 0 || p == NUM_PHASES - 1) write_all_team(16'hFFFF);
         else if (p == 1) write_all_team(16'h0000);
         else if (p % 2 == 1 && tbl_cnt > 0) write_all_team(tbl_id[$urandom_range(0, tbl_cnt - 1)]);
         else write_all_team(16'($urandom));
         case ($urandom_range(0, 3))
            0:       src_idle_pct = 0;
            1:       src_idle_pct = 10;
            2:       src_idle_pct = 30;
            default: src_idle_pct = 60;
         endcase
         case ($urandom_range(0, 3))
            0:       snk_idle_pct = 0;
            1:       snk_idle_pct = 10;
            2:       snk_idle_pct = 30;
            default: snk_idle_pct = 60;
         endcase
         // the closing phase runs at full rate on both sides
         if (p == NUM_PHASES - 1) no_idle = 1'b1;
         trend = TREND_MIX;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // swing between filling and draining so both ends get hit
            if (tbl_cnt >= MAX_SLOTS - 2 && $urandom_range(0, 3) == 0) trend = TREND_DRAIN;
            else if (tbl_cnt <= 1 && $urandom_range(0, 3) == 0) trend = TREND_FILL;
            else if ($urandom_range(0, 59) == 0) trend = trend_type'($urandom_range(0, 2));
            op = make_random_op(trend);
            send_req(op, 1'b0, none);
         end
      end

      // let the last results come back and make sure nothing extra follows
      wait_drained();
      repeat (END_SETTLE) @(posedge clock);

      if (awaited_rsp.size() != 0) begin
         $display("%0d results never arrived", awaited_rsp.size());
      end
      $display("ran %0d allocates, %0d releases, %0d lookups, %0d unused-mode items, %0d id writes",
               mode_seen[MODE_ALLOC], mode_seen[MODE_RELEASE], mode_seen[MODE_LOOKUP],
               mode_seen[MODE_SPARE], csr_writes);
      $display("%0d results checked: %0d no free slot, %0d id not found, %0d bad release",
               rsp_seen, status_seen[STAT_NO_FREE], status_seen[STAT_NOT_FOUND],
               status_seen[STAT_BAD_RELEASE]);
      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("slot_allocator_sorted_map_top verification clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("slot_allocator_sorted_map_top verification failed");
      end
      $finish;
   end

endmodule
